// ----- rtl/dtq_pkg.sv -----
`timescale 1ns / 1ps

package dtq_pkg;

   localparam int QUEUE_DEPTH  = 16;
   localparam int TIME_BITS    = 32;
   localparam int MAX_RESULTS  = 16;
   localparam int OP_BITS      = 2;
   localparam int DELAY_BITS   = 16;
   localparam int ID_BITS      = 16;
   localparam int TAG_BITS     = 8;
   localparam int KIND_BITS    = 2;
   localparam int REMOVED_BITS = 5;
   localparam int CNT_BITS     = $clog2(QUEUE_DEPTH + 1);
   localparam int RES_BITS     = $clog2(MAX_RESULTS + 1);

   localparam logic [OP_BITS-1:0] OP_REGISTER = 2'd0;
   localparam logic [OP_BITS-1:0] OP_CANCEL   = 2'd1;
   localparam logic [OP_BITS-1:0] OP_TICK     = 2'd2;

   localparam logic [KIND_BITS-1:0] KIND_REGISTERED = 2'd0;
   localparam logic [KIND_BITS-1:0] KIND_FULL       = 2'd1;
   localparam logic [KIND_BITS-1:0] KIND_CANCELLED  = 2'd2;
   localparam logic [KIND_BITS-1:0] KIND_EXPIRED    = 2'd3;

   typedef struct packed {
      logic [TIME_BITS-1:0] deadline;
      logic [ID_BITS-1:0]   ident;
      logic [TAG_BITS-1:0]  action;
   } entry_type;

   typedef struct packed {
      logic                cancel;
      logic                push;
      entry_type           ent;
      logic [CNT_BITS-1:0] cnt;
   } token_type;

   typedef struct packed {
      logic                 shift;
      logic                 collapse;
      logic [TIME_BITS-1:0] now;
   } cell_ctl_type;

   typedef struct packed {
      logic valid;
      logic gap;
      logic due;
   } cell_stat_type;

   typedef struct packed {
      logic                any_tok;
      logic                any_gap;
      logic                full;
      logic                head_due;
      logic                next_due;
      logic                exit_valid;
      logic [CNT_BITS-1:0] exit_cnt;
      entry_type           head;
   } chain_stat_type;

   function automatic logic earlier(input logic [TIME_BITS-1:0] a,
                                    input logic [TIME_BITS-1:0] b);
      logic [TIME_BITS-1:0] diff;
      diff = a - b;
      return diff[TIME_BITS-1];
   endfunction

endpackage

// ----- rtl/dtq_if.sv -----
`timescale 1ns / 1ps

interface dtq_req_if;
   logic                           valid;
   logic                           ready;
   logic [dtq_pkg::OP_BITS-1:0]    operation;
   logic [dtq_pkg::DELAY_BITS-1:0] delay;
   logic [dtq_pkg::ID_BITS-1:0]    timer_id;
   logic [dtq_pkg::TAG_BITS-1:0]   handler_tag;

   modport source (output valid, operation, delay, timer_id, handler_tag, input ready);
   modport sink (input valid, operation, delay, timer_id, handler_tag, output ready);
endinterface

interface dtq_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [dtq_pkg::KIND_BITS-1:0]    kind;
   logic [dtq_pkg::ID_BITS-1:0]      expired_id;
   logic [dtq_pkg::TAG_BITS-1:0]     expired_tag;
   logic [dtq_pkg::REMOVED_BITS-1:0] removed_count;
   logic                             last;

   modport source (output valid, kind, expired_id, expired_tag, removed_count, last,
                   input ready);
   modport sink (input valid, kind, expired_id, expired_tag, removed_count, last,
                 output ready);
endinterface

// ----- rtl/dtq_cell.sv -----
`timescale 1ns / 1ps

module dtq_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  dtq_pkg::cell_ctl_type  ctl,
   input  logic                   prev_valid,
   input  logic                   next_valid,
   input  dtq_pkg::entry_type     next_entry,
   input  logic                   in_tok_valid,
   input  dtq_pkg::token_type     in_tok,
   output logic                   out_tok_valid,
   output dtq_pkg::token_type     out_tok,
   output dtq_pkg::entry_type     entry,
   output dtq_pkg::cell_stat_type stat
);

   logic               valid_ff, valid_in;
   dtq_pkg::entry_type entry_ff, entry_in;
   logic               tok_valid_ff, tok_valid_in;
   dtq_pkg::token_type tok_ff, tok_in;

   always_comb begin
      valid_in     = valid_ff;
      entry_in     = entry_ff;
      tok_valid_in = 1'b0;
      tok_in       = in_tok;
      if (ctl.shift) begin
         valid_in = next_valid;
         entry_in = next_entry;
      end else if (ctl.collapse) begin
         if (!valid_ff && next_valid) begin
            valid_in = 1'b1;
            entry_in = next_entry;
         end else if (valid_ff && !prev_valid) begin
            valid_in = 1'b0;
         end
      end else if (in_tok_valid) begin
         if (in_tok.cancel) begin
            tok_valid_in = 1'b1;
            if (valid_ff && entry_ff.ident == in_tok.ent.ident) begin
               valid_in   = 1'b0;
               tok_in.cnt = in_tok.cnt + dtq_pkg::CNT_BITS'(1);
            end
         end else if (!valid_ff) begin
            valid_in = 1'b1;
            entry_in = in_tok.ent;
         end else if (in_tok.push || dtq_pkg::earlier(in_tok.ent.deadline, entry_ff.deadline))
         begin
            entry_in     = in_tok.ent;
            tok_valid_in = 1'b1;
            tok_in.ent   = entry_ff;
            tok_in.push  = 1'b1;
         end else begin
            tok_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         tok_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         tok_valid_ff <= tok_valid_in;
      end
      entry_ff <= entry_in;
      tok_ff   <= tok_in;
   end

   assign out_tok_valid = tok_valid_ff;
   assign out_tok       = tok_ff;
   assign entry         = entry_ff;
   assign stat.valid    = valid_ff;
   assign stat.gap      = valid_ff && !prev_valid;
   assign stat.due      = valid_ff && !dtq_pkg::earlier(ctl.now, entry_ff.deadline);

endmodule

// ----- rtl/dtq_chain.sv -----
`timescale 1ns / 1ps

module dtq_chain (
   input  logic                    clock,
   input  logic                    reset,
   input  dtq_pkg::cell_ctl_type   ctl,
   input  logic                    inject_valid,
   input  dtq_pkg::token_type      inject,
   output dtq_pkg::chain_stat_type stat
);

   localparam int N = dtq_pkg::QUEUE_DEPTH;

   dtq_pkg::cell_stat_type cell_stat [N];
   dtq_pkg::entry_type     ent       [N];
   dtq_pkg::token_type     tok       [N];
   logic [N-1:0]           tok_valid;
   logic [N-1:0]           valid_vec;
   logic [N-1:0]           gap_vec;
   logic [N-1:0]           due_vec;

   for (genvar i = 0; i < N; i++) begin : g_cell
      logic               prev_valid;
      logic               next_valid;
      dtq_pkg::entry_type next_entry;
      logic               up_valid;
      dtq_pkg::token_type up_tok;

      if (i == 0) begin : g_head
         assign prev_valid = 1'b1;
         assign up_valid   = inject_valid;
         assign up_tok     = inject;
      end else begin : g_body
         assign prev_valid = valid_vec[i-1];
         assign up_valid   = tok_valid[i-1];
         assign up_tok     = tok[i-1];
      end

      if (i == N - 1) begin : g_tail
         assign next_valid = 1'b0;
         assign next_entry = ent[i];
      end else begin : g_inner
         assign next_valid = valid_vec[i+1];
         assign next_entry = ent[i+1];
      end

      dtq_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .ctl           (ctl),
         .prev_valid    (prev_valid),
         .next_valid    (next_valid),
         .next_entry    (next_entry),
         .in_tok_valid  (up_valid),
         .in_tok        (up_tok),
         .out_tok_valid (tok_valid[i]),
         .out_tok       (tok[i]),
         .entry         (ent[i]),
         .stat          (cell_stat[i])
      );

      assign valid_vec[i] = cell_stat[i].valid;
      assign gap_vec[i]   = cell_stat[i].gap;
      assign due_vec[i]   = cell_stat[i].due;
   end

   assign stat.any_tok    = |tok_valid;
   assign stat.any_gap    = |gap_vec;
   assign stat.full       = valid_vec[N-1];
   assign stat.head_due   = due_vec[0];
   assign stat.next_due   = due_vec[1];
   assign stat.exit_valid = tok_valid[N-1];
   assign stat.exit_cnt   = tok[N-1].cnt;
   assign stat.head       = ent[0];

endmodule

// ----- rtl/deadline_timer_queue.sv -----
`timescale 1ns / 1ps

// Sorted timer event queue.
// req_chan carries one operation per beat: register a timer (deadline = now + delay),
// cancel every entry with a given id, or tick the clock of the queue by one unit.
// rsp_chan returns results: registered or queue full for a register, the number of
// removed entries for a cancel, and one beat per expired entry for a tick, with last
// set on the final beat of each operation. A tick with nothing due returns no beat.
// One operation is in flight at a time; req_chan.ready is high only when idle.
// A register answers from ST_DECODE through the output register; the new entry then
// walks the cell row, one cell a cycle, and the next request waits until it settles.
// A cancel walks the row, answers, then closes the gaps left behind, one cell a cycle.
// A tick emits one due entry per cycle from the head of the row, at most MAX_RESULTS,
// as long as rsp_chan is not stalled.
// Reset empties the queue and clears the time; entry payloads need no clearing.
// A stalled rsp_chan holds its beat in the output register and stalls the next answer.

module deadline_timer_queue (
   input logic             clock,
   input logic             reset,
   dtq_req_if.sink         req_chan,
   dtq_rsp_if.source       rsp_chan
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_INSERT,
      ST_CANCEL,
      ST_REPORT,
      ST_COLLAPSE,
      ST_EXPIRE
   } state_type;

   state_type                          state_ff, state_in;
   logic [dtq_pkg::OP_BITS-1:0]        op_ff, op_in;
   logic [dtq_pkg::DELAY_BITS-1:0]     delay_ff, delay_in;
   logic [dtq_pkg::ID_BITS-1:0]        id_ff, id_in;
   logic [dtq_pkg::TAG_BITS-1:0]       tag_ff, tag_in;
   logic [dtq_pkg::TIME_BITS-1:0]      time_ff, time_in;
   logic [dtq_pkg::RES_BITS-1:0]       n_ff, n_in;
   logic [dtq_pkg::CNT_BITS-1:0]       removed_ff, removed_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic [dtq_pkg::KIND_BITS-1:0]      rsp_kind_ff, rsp_kind_in;
   logic [dtq_pkg::ID_BITS-1:0]        rsp_id_ff, rsp_id_in;
   logic [dtq_pkg::TAG_BITS-1:0]       rsp_tag_ff, rsp_tag_in;
   logic [dtq_pkg::REMOVED_BITS-1:0]   rsp_removed_ff, rsp_removed_in;
   logic                               rsp_last_ff, rsp_last_in;

   logic                               rsp_load;
   logic                               inject_valid;
   dtq_pkg::token_type                 inject;
   dtq_pkg::cell_ctl_type              ctl;
   dtq_pkg::chain_stat_type            chain_stat;

   dtq_chain u_chain (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .inject_valid (inject_valid),
      .inject       (inject),
      .stat         (chain_stat)
   );

   assign rsp_load = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      delay_in       = delay_ff;
      id_in          = id_ff;
      tag_in         = tag_ff;
      time_in        = time_ff;
      n_in           = n_ff;
      removed_in     = removed_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_id_in      = rsp_id_ff;
      rsp_tag_in     = rsp_tag_ff;
      rsp_removed_in = rsp_removed_ff;
      rsp_last_in    = rsp_last_ff;

      inject_valid        = 1'b0;
      inject.cancel       = (op_ff == dtq_pkg::OP_CANCEL);
      inject.push         = 1'b0;
      inject.ent.deadline = time_ff + dtq_pkg::TIME_BITS'(delay_ff);
      inject.ent.ident    = id_ff;
      inject.ent.action   = tag_ff;
      inject.cnt          = '0;

      ctl.shift    = 1'b0;
      ctl.collapse = (state_ff == ST_COLLAPSE);
      ctl.now      = time_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               op_in    = req_chan.operation;
               delay_in = req_chan.delay;
               id_in    = req_chan.timer_id;
               tag_in   = req_chan.handler_tag;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (op_ff)
               dtq_pkg::OP_REGISTER: begin
                  if (rsp_load) begin
                     rsp_valid_in   = 1'b1;
                     rsp_kind_in    = chain_stat.full ? dtq_pkg::KIND_FULL
                                                      : dtq_pkg::KIND_REGISTERED;
                     rsp_id_in      = '0;
                     rsp_tag_in     = '0;
                     rsp_removed_in = '0;
                     rsp_last_in    = 1'b1;
                     if (chain_stat.full) begin
                        state_in = ST_IDLE;
                     end else begin
                        inject_valid = 1'b1;
                        state_in     = ST_INSERT;
                     end
                  end
               end
               dtq_pkg::OP_CANCEL: begin
                  inject_valid = 1'b1;
                  state_in     = ST_CANCEL;
               end
               dtq_pkg::OP_TICK: begin
                  time_in  = time_ff + dtq_pkg::TIME_BITS'(1);
                  n_in     = '0;
                  state_in = ST_EXPIRE;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_INSERT: begin
            if (!chain_stat.any_tok) begin
               state_in = ST_IDLE;
            end
         end
         ST_CANCEL: begin
            if (chain_stat.exit_valid) begin
               removed_in = chain_stat.exit_cnt;
               state_in   = ST_REPORT;
            end
         end
         ST_REPORT: begin
            if (rsp_load) begin
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = dtq_pkg::KIND_CANCELLED;
               rsp_id_in      = '0;
               rsp_tag_in     = '0;
               rsp_removed_in = dtq_pkg::REMOVED_BITS'(removed_ff);
               rsp_last_in    = 1'b1;
               state_in       = ST_COLLAPSE;
            end
         end
         ST_COLLAPSE: begin
            if (!chain_stat.any_gap) begin
               state_in = ST_IDLE;
            end
         end
         ST_EXPIRE: begin
            if (!chain_stat.head_due) begin
               state_in = ST_IDLE;
            end else if (rsp_load) begin
               rsp_valid_in   = 1'b1;
               rsp_kind_in    = dtq_pkg::KIND_EXPIRED;
               rsp_id_in      = chain_stat.head.ident;
               rsp_tag_in     = chain_stat.head.action;
               rsp_removed_in = '0;
               rsp_last_in    = !chain_stat.next_due ||
                                (n_ff == dtq_pkg::RES_BITS'(dtq_pkg::MAX_RESULTS - 1));
               ctl.shift      = 1'b1;
               n_in           = n_ff + dtq_pkg::RES_BITS'(1);
               if (rsp_last_in) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         time_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         time_ff      <= time_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff          <= op_in;
      delay_ff       <= delay_in;
      id_ff          <= id_in;
      tag_ff         <= tag_in;
      n_ff           <= n_in;
      removed_ff     <= removed_in;
      rsp_kind_ff    <= rsp_kind_in;
      rsp_id_ff      <= rsp_id_in;
      rsp_tag_ff     <= rsp_tag_in;
      rsp_removed_ff <= rsp_removed_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.kind          = rsp_kind_ff;
   assign rsp_chan.expired_id    = rsp_id_ff;
   assign rsp_chan.expired_tag   = rsp_tag_ff;
   assign rsp_chan.removed_count = rsp_removed_ff;
   assign rsp_chan.last          = rsp_last_ff;

`ifndef ASSERT_OFF
   a_insert_absorbed: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INSERT |-> !chain_stat.exit_valid)
      else $error("insert token left the cell row");

   a_idle_compact: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !chain_stat.any_gap)
      else $error("queue has a gap while idle");

   a_expire_next_due: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXPIRE && ctl.shift && !rsp_last_in) |=> chain_stat.head_due)
      else $error("expiry beat without last but head not due");
`endif

endmodule
